// ===== hw/rtl/mfde_pkg.sv =====
package mfde_pkg;

   localparam int SCREEN_COLUMNS_DEF  = 64;
   localparam int SCREEN_ROWS_DEF     = 32;
   localparam int GLYPH_MAX_WIDTH_DEF = 32;

   localparam int COORD_W  = 16;
   localparam int ACTION_W = 3;
   localparam int GLYPH_W  = 32;
   localparam int GWIDTH_W = 6;
   localparam int BYTE_W   = 8;

   localparam logic [ACTION_W-1:0] ACT_PIXEL  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_HLINE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_VLINE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RECT   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_GLYPH  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FILL   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

   localparam logic [BYTE_W-1:0] BYTE_ONES  = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZEROS = 8'h00;

endpackage

// ===== hw/rtl/mfde_store.sv =====
module mfde_store
   import mfde_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mfde_pixel_unit.sv =====
module mfde_pixel_unit
   import mfde_pkg::*;
#(
   parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
   parameter int ADDR_W         = 8
) (
   input  logic [COORD_W-1:0] x,
   input  logic [COORD_W-1:0] y,
   input  logic               value,
   input  logic [BYTE_W-1:0]  old_byte,
   output logic               on_screen,
   output logic [ADDR_W-1:0]  addr,
   output logic [BYTE_W-1:0]  new_byte
);

   localparam int ROW_BYTES = (SCREEN_COLUMNS + 7) / 8;

   logic [31:0]       addr_wide;
   logic [BYTE_W-1:0] mask;

   always_comb begin
      on_screen = (x < COORD_W'(SCREEN_COLUMNS)) && (y < COORD_W'(SCREEN_ROWS));
      // Row-major byte address; only meaningful when the pixel is on screen.
      addr_wide = 32'(y) * 32'(ROW_BYTES) + 32'(x >> 3);
      addr      = addr_wide[ADDR_W-1:0];
      // Column 0 of each byte is its most significant bit.
      mask      = 8'h80 >> x[2:0];
      new_byte  = value ? (old_byte | mask) : (old_byte & ~mask);
   end

endmodule

// ===== hw/rtl/mono_framebuffer_draw_engine_core.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  action, coordinates, pixel value, glyph row
// rsp      out        rsp_valid/rsp_ready  read_data
//
// After the accepting edge req_ready stays low until the request is finished: its pixel
// steps (pixel, lines, glyph row, outline), its store sweep (fill) or its store read (read).
// An on-screen pixel step is a store read then a write back; an off-screen step skips both.
// A finished request waits while the previous result is still unaccepted.
// Reset clears the store one byte per cycle, all STORE_BYTES bytes (256 at the defaults),
// before req_ready rises.
module mono_framebuffer_draw_engine_core
   import mfde_pkg::*;
#(
   parameter int SCREEN_COLUMNS  = SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS     = SCREEN_ROWS_DEF,
   parameter int GLYPH_MAX_WIDTH = GLYPH_MAX_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [COORD_W-1:0]  req_x_start,
   input  logic [COORD_W-1:0]  req_x_end,
   input  logic [COORD_W-1:0]  req_y_start,
   input  logic [COORD_W-1:0]  req_y_end,
   input  logic                req_pixel_value,
   input  logic [GLYPH_W-1:0]  req_glyph_row_bits,
   input  logic [GWIDTH_W-1:0] req_glyph_width,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_read_data
);

   localparam int ROW_BYTES   = (SCREEN_COLUMNS + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * SCREEN_ROWS;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SWEEP    = 3'd1;
   localparam logic [2:0] ST_SEG      = 3'd2;
   localparam logic [2:0] ST_PIX_RD   = 3'd3;
   localparam logic [2:0] ST_PIX_WR   = 3'd4;
   localparam logic [2:0] ST_RD_ISSUE = 3'd5;
   localparam logic [2:0] ST_RD_DATA  = 3'd6;
   localparam logic [2:0] ST_FINISH   = 3'd7;

   localparam logic [1:0] SEG_FIRST  = 2'd0;
   localparam logic [1:0] SEG_BOTTOM = 2'd1;
   localparam logic [1:0] SEG_LAST   = 2'd3;

   logic [2:0]          state_ff, state_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [1:0]          seg_ff, seg_in;
   logic [COORD_W-1:0]  xs_ff, xs_in, xe_ff, xe_in, ys_ff, ys_in, ye_ff, ye_in;
   logic [COORD_W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, end_ff, end_in;
   logic                vert_ff, vert_in, glyph_ff, glyph_in, pv_ff, pv_in;
   logic [GWIDTH_W-1:0] cnt_ff, cnt_in, gw_ff, gw_in;
   logic [GLYPH_W-1:0]  bits_ff, bits_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic [BYTE_W-1:0]   fill_ff, fill_in;
   logic                sweep_rsp_ff, sweep_rsp_in;
   logic [BYTE_W-1:0]   result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                on_screen;
   logic [ADDR_W-1:0]   pix_addr;
   logic [BYTE_W-1:0]   new_byte;
   logic [BYTE_W-1:0]   rd_data;
   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [BYTE_W-1:0]   wr_data;
   logic                pix_value;
   logic                walk_on;
   logic                last_seg;
   logic                req_fire;

   mfde_pixel_unit #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS   (SCREEN_ROWS),
      .ADDR_W        (ADDR_W)
   ) u_pixel (
      .x        (cur_x_ff),
      .y        (cur_y_ff),
      .value    (pix_value),
      .old_byte (rd_data),
      .on_screen(on_screen),
      .addr     (pix_addr),
      .new_byte (new_byte)
   );

   mfde_store #(
      .DEPTH (STORE_BYTES),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(pix_addr),
      .rd_data(rd_data)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign pix_value     = glyph_ff ? bits_ff[GLYPH_W-1] : pv_ff;
   assign last_seg      = (act_ff != ACT_RECT) || (seg_ff == SEG_LAST);

   always_comb begin
      if (glyph_ff) begin
         walk_on = cnt_ff < gw_ff;
      end else if (vert_ff) begin
         walk_on = (cur_y_ff <= end_ff) && (cur_y_ff < COORD_W'(SCREEN_ROWS));
      end else begin
         walk_on = (cur_x_ff <= end_ff) && (cur_x_ff < COORD_W'(SCREEN_COLUMNS));
      end
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      seg_in       = seg_ff;
      xs_in        = xs_ff;
      xe_in        = xe_ff;
      ys_in        = ys_ff;
      ye_in        = ye_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_in       = end_ff;
      vert_in      = vert_ff;
      glyph_in     = glyph_ff;
      pv_in        = pv_ff;
      cnt_in       = cnt_ff;
      gw_in        = gw_ff;
      bits_in      = bits_ff;
      sweep_in     = sweep_ff;
      fill_in      = fill_ff;
      sweep_rsp_in = sweep_rsp_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = pix_addr;
      wr_data      = new_byte;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in    = req_action;
               xs_in     = req_x_start;
               xe_in     = req_x_end;
               ys_in     = req_y_start;
               ye_in     = req_y_end;
               pv_in     = req_pixel_value;
               bits_in   = req_glyph_row_bits;
               gw_in     = (req_glyph_width > GWIDTH_W'(GLYPH_MAX_WIDTH)) ?
                           GWIDTH_W'(GLYPH_MAX_WIDTH) : req_glyph_width;
               seg_in    = SEG_FIRST;
               result_in = BYTE_ZEROS;
               cur_x_in  = req_x_start;
               cur_y_in  = req_y_start;
               case (req_action)
                  ACT_FILL: begin
                     fill_in      = req_pixel_value ? BYTE_ONES : BYTE_ZEROS;
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  ACT_READ:   state_in = ST_RD_ISSUE;
                  ACT_UNUSED: state_in = ST_FINISH;
                  default:    state_in = ST_SEG;
               endcase
            end
         end

         ST_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = fill_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = sweep_rsp_ff ? ST_FINISH : ST_IDLE;
            end
         end

         ST_SEG: begin
            // Every drawing action other than fill is one or more straight walks of the pixel step.
            cur_x_in = xs_ff;
            cur_y_in = ys_ff;
            end_in   = xe_ff;
            vert_in  = 1'b0;
            glyph_in = 1'b0;
            cnt_in   = '0;
            case (act_ff)
               ACT_PIXEL: end_in = xs_ff;
               ACT_VLINE: begin
                  vert_in = 1'b1;
                  end_in  = ye_ff;
               end
               ACT_GLYPH: glyph_in = 1'b1;
               ACT_RECT: begin
                  case (seg_ff)
                     SEG_FIRST:  cur_y_in = ys_ff;
                     SEG_BOTTOM: cur_y_in = ye_ff;
                     default: begin
                        // Side edges skip the corner rows, with 16-bit wrap.
                        vert_in  = 1'b1;
                        cur_x_in = (seg_ff == SEG_LAST) ? xe_ff : xs_ff;
                        cur_y_in = ys_ff + 16'd1;
                        end_in   = ye_ff - 16'd1;
                     end
                  endcase
               end
               default: end_in = xe_ff;
            endcase
            state_in = ST_PIX_RD;
         end

         ST_PIX_RD: begin
            if (!walk_on) begin
               if (last_seg) begin
                  state_in = ST_FINISH;
               end else begin
                  seg_in   = seg_ff + 1'b1;
                  state_in = ST_SEG;
               end
            end else if (on_screen) begin
               rd_en    = 1'b1;
               state_in = ST_PIX_WR;
            end else if (glyph_ff) begin
               cur_x_in = cur_x_ff + 16'd1;
               cnt_in   = cnt_ff + 1'b1;
               bits_in  = bits_ff << 1;
            end else if (vert_ff) begin
               cur_y_in = cur_y_ff + 16'd1;
            end else begin
               cur_x_in = cur_x_ff + 16'd1;
            end
         end

         ST_PIX_WR: begin
            wr_en = 1'b1;
            if (glyph_ff) begin
               cur_x_in = cur_x_ff + 16'd1;
               cnt_in   = cnt_ff + 1'b1;
               bits_in  = bits_ff << 1;
            end else if (vert_ff) begin
               cur_y_in = cur_y_ff + 16'd1;
            end else begin
               cur_x_in = cur_x_ff + 16'd1;
            end
            state_in = ST_PIX_RD;
         end

         ST_RD_ISSUE: begin
            rd_en    = 1'b1;
            state_in = ST_RD_DATA;
         end

         ST_RD_DATA: begin
            result_in = on_screen ? rd_data : BYTE_ZEROS;
            state_in  = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         fill_ff      <= BYTE_ZEROS;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seg_ff       <= SEG_FIRST;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fill_ff      <= fill_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_ff       <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      xs_ff       <= xs_in;
      xe_ff       <= xe_in;
      ys_ff       <= ys_in;
      ye_ff       <= ye_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      end_ff      <= end_in;
      vert_ff     <= vert_in;
      glyph_ff    <= glyph_in;
      pv_ff       <= pv_in;
      cnt_ff      <= cnt_in;
      gw_ff       <= gw_in;
      bits_ff     <= bits_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
